// ===== rtl/ccle_pkg.sv =====
// Shared types, codes and helpers for the cheat code line engine.
// No dependencies; used by ccle_decode and cheat_code_line_engine_top.
package ccle_pkg;

  localparam logic [1:0] ST_CONT    = 2'd0;
  localparam logic [1:0] ST_END     = 2'd1;
  localparam logic [1:0] ST_FAIL    = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  localparam logic [1:0] ACT_EXEC  = 2'd0;
  localparam logic [1:0] ACT_HWR   = 2'd1;
  localparam logic [1:0] ACT_HRD   = 2'd2;

  localparam logic [1:0] SKIP_NONE  = 2'd0;
  localparam logic [1:0] SKIP_LINES = 2'd1;
  localparam logic [1:0] SKIP_ENDIF = 2'd2;
  localparam logic [1:0] SKIP_ALL   = 2'd3;

  localparam logic [2:0] CMP_EQ  = 3'd1;
  localparam logic [2:0] CMP_NE  = 3'd2;
  localparam logic [2:0] CMP_SLT = 3'd3;
  localparam logic [2:0] CMP_SGT = 3'd4;
  localparam logic [2:0] CMP_ULT = 3'd5;
  localparam logic [2:0] CMP_UGT = 3'd6;

  localparam logic [2:0] ZC_END  = 3'd0;
  localparam logic [2:0] ZC_NOP  = 3'd2;
  localparam logic [2:0] ZC_FILL = 3'd4;

  localparam logic [31:0] ENDIF_WORD = 32'h4000_0000;
  localparam logic [31:0] SELF_LO    = 32'h0000_2000;
  localparam logic [31:0] SELF_HI    = 32'h0000_3000;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_WRITE,
    OP_HOSTRD,
    OP_PTR,
    OP_ADD,
    OP_CMP
  } op_e;

  typedef struct packed {
    logic [1:0]  status;
    op_e         op;
    logic        halted;
    logic [1:0]  skip_mode;
    logic [1:0]  skip_left;
    logic        fill_pending;
    logic [31:0] pending;
    logic [24:0] addr;
    logic [1:0]  size;
    logic [24:0] reps;
    logic [31:0] step;
    logic [31:0] val;
    logic [31:0] vinc;
  } plan_t;

  function automatic logic [31:0] align_val(input logic [31:0] v, input logic [1:0] size);
    logic [31:0] r;
    case (size)
      2'd0:    r = {v[7:0], 24'd0};
      2'd1:    r = {v[15:0], 16'd0};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic cmp_ok(input logic [2:0] kind, input logic [31:0] m,
                                  input logic [31:0] v);
    logic r;
    case (kind)
      CMP_EQ:  r = (m == v);
      CMP_NE:  r = (m != v);
      CMP_SLT: r = ($signed(m) < $signed(v));
      CMP_SGT: r = ($signed(m) > $signed(v));
      CMP_ULT: r = (m < v);
      CMP_UGT: r = (m > v);
      default: r = ((m & v) != 32'd0);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ccle_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module ccle_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] addr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [2**ADDR_BITS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== rtl/ccle_decode.sv =====
// Decodes one request (code line or host access) into a sequencer plan.
// Depends on ccle_pkg.
module ccle_decode #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic [1:0]      action_i,
  input  logic            first_line_i,
  input  logic [31:0]     code_word_i,
  input  logic [31:0]     data_word_i,
  input  logic [15:0]     host_address_i,
  input  logic [7:0]      host_byte_i,
  input  logic            halted_i,
  input  logic [1:0]      skip_mode_i,
  input  logic [1:0]      skip_left_i,
  input  logic            fill_pending_i,
  input  logic [31:0]     pending_i,
  output ccle_pkg::plan_t plan_o
);

  localparam logic [25:0] MemBytes = 26'(1) << MEM_ADDR_BITS;

  logic [31:0] cw, dw;
  logic [1:0]  csize, csub, psize;
  logic [2:0]  ctype;
  logic [25:0] fill_n;
  logic [31:0] ainc;

  assign cw     = code_word_i;
  assign dw     = data_word_i;
  assign csize  = cw[26:25];
  assign ctype  = cw[29:27];
  assign csub   = cw[31:30];
  assign psize  = pending_i[26:25];
  assign fill_n = 26'(dw[31:8]) + 26'd1;
  assign ainc   = {{16{dw[15]}}, dw[15:0]};

  always_comb begin
    ccle_pkg::plan_t p;
    p              = '0;
    p.status       = ccle_pkg::ST_CONT;
    p.op           = ccle_pkg::OP_NONE;
    p.halted       = halted_i;
    p.skip_mode    = skip_mode_i;
    p.skip_left    = skip_left_i;
    p.fill_pending = fill_pending_i;
    p.pending      = pending_i;
    p.reps         = 25'd1;
    case (action_i)
      ccle_pkg::ACT_EXEC: begin
        if (first_line_i) begin
          p.halted       = 1'b0;
          p.skip_mode    = ccle_pkg::SKIP_NONE;
          p.skip_left    = 2'd0;
          p.fill_pending = 1'b0;
          p.pending      = 32'd0;
        end
        if (p.halted) begin
          p.status = ccle_pkg::ST_IGNORED;
        end else if (p.skip_mode == ccle_pkg::SKIP_LINES) begin
          p.skip_left = p.skip_left - 2'd1;
          if (p.skip_left == 2'd0) begin
            p.skip_mode = ccle_pkg::SKIP_NONE;
          end
        end else if (p.skip_mode == ccle_pkg::SKIP_ALL) begin
          p.status = ccle_pkg::ST_END;
        end else if (p.skip_mode == ccle_pkg::SKIP_ENDIF) begin
          if (cw == 32'd0 && dw == ccle_pkg::ENDIF_WORD) begin
            p.skip_mode = ccle_pkg::SKIP_NONE;
          end
        end else if (p.fill_pending) begin
          p.fill_pending = 1'b0;
          if (p.pending[26:25] == 2'd3) begin
            p.status = ccle_pkg::ST_FAIL;
          end else begin
            p.op   = (dw[23:16] == 8'd0) ? ccle_pkg::OP_NONE : ccle_pkg::OP_WRITE;
            p.addr = p.pending[24:0];
            p.size = p.pending[26:25];
            p.reps = 25'(dw[23:16]);
            p.step = ainc << psize;
            p.val  = cw;
            p.vinc = {{24{dw[31]}}, dw[31:24]};
          end
        end else if (cw >= ccle_pkg::SELF_LO && cw < ccle_pkg::SELF_HI) begin
          p.status = ccle_pkg::ST_FAIL;
        end else if (cw == 32'd0) begin
          case (dw[31:29])
            ccle_pkg::ZC_END: p.status = ccle_pkg::ST_END;
            ccle_pkg::ZC_NOP: p.status = ccle_pkg::ST_CONT;
            ccle_pkg::ZC_FILL: begin
              if (dw[26:25] == 2'd3) begin
                p.status = ccle_pkg::ST_FAIL;
              end else begin
                p.fill_pending = 1'b1;
                p.pending      = dw;
              end
            end
            default: p.status = ccle_pkg::ST_FAIL;
          endcase
        end else if (ctype == 3'd0) begin
          p.addr = cw[24:0];
          case (csub)
            2'd0: begin
              p.op  = ccle_pkg::OP_WRITE;
              p.val = dw;
              if (csize == 2'd0) begin
                p.size = 2'd0;
                p.step = 32'd1;
                p.reps = (fill_n > MemBytes) ? 25'(MemBytes) : 25'(fill_n);
              end else if (csize == 2'd1) begin
                p.size = 2'd1;
                p.step = 32'd2;
                p.reps = 25'(dw[31:16]) + 25'd1;
              end else begin
                p.size = 2'd2;
              end
            end
            2'd1: begin
              p.op   = ccle_pkg::OP_PTR;
              p.size = 2'd2;
            end
            2'd2: begin
              if (csize == 2'd3) begin
                p.status = ccle_pkg::ST_FAIL;
              end else begin
                p.op   = ccle_pkg::OP_ADD;
                p.size = csize;
                p.val  = dw;
              end
            end
            default: p.status = ccle_pkg::ST_FAIL;
          endcase
        end else begin
          p.op   = ccle_pkg::OP_CMP;
          p.addr = cw[24:0];
          case (csize)
            2'd0:    begin p.size = 2'd0; p.val = {24'd0, dw[7:0]};  end
            2'd1:    begin p.size = 2'd1; p.val = {16'd0, dw[15:0]}; end
            default: begin p.size = 2'd2; p.val = dw;                end
          endcase
        end
        if (p.status == ccle_pkg::ST_END || p.status == ccle_pkg::ST_FAIL) begin
          p.halted = 1'b1;
        end
      end
      ccle_pkg::ACT_HWR: begin
        p.op   = ccle_pkg::OP_WRITE;
        p.addr = {9'd0, host_address_i};
        p.val  = {24'd0, host_byte_i};
      end
      ccle_pkg::ACT_HRD: begin
        p.op   = ccle_pkg::OP_HOSTRD;
        p.addr = {9'd0, host_address_i};
      end
      default: p.op = ccle_pkg::OP_NONE;
    endcase
    plan_o = p;
  end

endmodule

// ===== rtl/cheat_code_line_engine_top.sv =====
// Top level of the cheat code line engine: request/response streams, sequencer, patch RAM.
// Depends on ccle_pkg, ccle_decode and ccle_ram.
//
// Usage: one request enters on s_axis (tuser = action: execute line, host byte write,
// host byte read) and yields exactly one response on m_axis (status, read byte).
// The block takes one request at a time; s_axis_tready is low from accept until the
// response has been taken. All memory traffic goes byte by byte through one RAM port:
// each byte written passes S_WR, each byte read passes S_RD and then S_RDC. A request
// goes from accept through S_EXEC (decode), then S_RD/S_RDC for bytes read and S_POST
// when anything is read, then S_WR for bytes written, then S_OUT; the next request is
// taken in S_IDLE after the response. Fills and slides write byte by byte in S_WR.
// After reset the memory is cleared one byte per cycle, all 2^MEM_ADDR_BITS bytes, and
// no request is taken until the clear is done. A stalled m_axis holds the response and
// the block accepts nothing until it is taken.
module cheat_code_line_engine_top #(
  parameter int MEM_ADDR_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] first_line, [32:1] code_word, [64:33] data_word, [80:65] host_address,
  // [88:81] host_byte, [95:89] zero
  input  logic [95:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [9:2] read_byte, [15:10] zero
  output logic [15:0] m_axis_tdata
);

  localparam int AW = MEM_ADDR_BITS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_EXEC, S_RD, S_RDC, S_POST, S_WR, S_OUT
  } state_e;

  state_e          state_q;
  logic [1:0]      act_q;
  logic            first_q;
  logic [31:0]     cw_q, dw_q;
  logic [15:0]     haddr_q;
  logic [7:0]      hbyte_q;
  logic            halted_q, fill_pending_q;
  logic [1:0]      skip_mode_q, skip_left_q;
  logic [31:0]     pending_q;
  ccle_pkg::op_e   op_q;
  logic [AW-1:0]   addr_q, base_q, step_q;
  logic [1:0]      size_q;
  logic [2:0]      cnt_q;
  logic [24:0]     reps_q;
  logic [31:0]     val_q, vinc_q, wsh_q, acc_q;
  logic [1:0]      status_q;
  logic [7:0]      rb_q;
  ccle_pkg::plan_t plan;
  logic            ram_we;
  logic [7:0]      ram_wdata, ram_rdata;
  logic [31:0]     nval, sum;
  logic [1:0]      psize;
  logic [AW-1:0]   poff;

  ccle_decode #(.MEM_ADDR_BITS(MEM_ADDR_BITS)) u_decode (
    .action_i       (act_q),
    .first_line_i   (first_q),
    .code_word_i    (cw_q),
    .data_word_i    (dw_q),
    .host_address_i (haddr_q),
    .host_byte_i    (hbyte_q),
    .halted_i       (halted_q),
    .skip_mode_i    (skip_mode_q),
    .skip_left_i    (skip_left_q),
    .fill_pending_i (fill_pending_q),
    .pending_i      (pending_q),
    .plan_o         (plan)
  );

  assign ram_we    = (state_q == S_CLEAR) || (state_q == S_WR);
  assign ram_wdata = (state_q == S_CLEAR) ? 8'd0 : wsh_q[31:24];

  ccle_ram #(.WIDTH(8), .ADDR_BITS(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (addr_q),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {6'd0, rb_q, status_q};

  assign nval  = val_q + vinc_q;
  assign sum   = acc_q + val_q;
  assign psize = (cw_q[26:25] == 2'd3) ? 2'd2 : cw_q[26:25];
  always_comb begin
    case (cw_q[26:25])
      2'd0:    poff = AW'(dw_q[31:8]);
      2'd1:    poff = AW'({dw_q[31:16], 1'b0});
      default: poff = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      addr_q         <= '0;
      halted_q       <= 1'b0;
      skip_mode_q    <= ccle_pkg::SKIP_NONE;
      skip_left_q    <= 2'd0;
      fill_pending_q <= 1'b0;
      pending_q      <= 32'd0;
      op_q           <= ccle_pkg::OP_NONE;
      cnt_q          <= 3'd0;
      reps_q         <= 25'd0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          addr_q <= addr_q + AW'(1);
          if (addr_q == {AW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act_q   <= s_axis_tuser;
            first_q <= s_axis_tdata[0];
            cw_q    <= s_axis_tdata[32:1];
            dw_q    <= s_axis_tdata[64:33];
            haddr_q <= s_axis_tdata[80:65];
            hbyte_q <= s_axis_tdata[88:81];
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          halted_q       <= plan.halted;
          skip_mode_q    <= plan.skip_mode;
          skip_left_q    <= plan.skip_left;
          fill_pending_q <= plan.fill_pending;
          pending_q      <= plan.pending;
          status_q       <= plan.status;
          rb_q           <= 8'd0;
          op_q           <= plan.op;
          addr_q         <= AW'(plan.addr);
          base_q         <= AW'(plan.addr);
          step_q         <= AW'(plan.step);
          size_q         <= plan.size;
          cnt_q          <= 3'd1 << plan.size;
          reps_q         <= plan.reps;
          val_q          <= plan.val;
          vinc_q         <= plan.vinc;
          wsh_q          <= ccle_pkg::align_val(plan.val, plan.size);
          acc_q          <= 32'd0;
          case (plan.op)
            ccle_pkg::OP_NONE:  state_q <= S_OUT;
            ccle_pkg::OP_WRITE: state_q <= S_WR;
            default:            state_q <= S_RD;
          endcase
        end
        S_RD: begin
          state_q <= S_RDC;
        end
        S_RDC: begin
          acc_q  <= {acc_q[23:0], ram_rdata};
          addr_q <= addr_q + AW'(1);
          if (cnt_q == 3'd1) begin
            state_q <= S_POST;
          end else begin
            cnt_q   <= cnt_q - 3'd1;
            state_q <= S_RD;
          end
        end
        S_POST: begin
          case (op_q)
            ccle_pkg::OP_HOSTRD: begin
              rb_q    <= acc_q[7:0];
              state_q <= S_OUT;
            end
            ccle_pkg::OP_PTR: begin
              addr_q  <= acc_q[AW-1:0] + poff;
              size_q  <= psize;
              cnt_q   <= 3'd1 << psize;
              reps_q  <= 25'd1;
              wsh_q   <= ccle_pkg::align_val(dw_q, psize);
              state_q <= S_WR;
            end
            ccle_pkg::OP_ADD: begin
              addr_q  <= base_q;
              cnt_q   <= 3'd1 << size_q;
              reps_q  <= 25'd1;
              wsh_q   <= ccle_pkg::align_val(sum, size_q);
              state_q <= S_WR;
            end
            ccle_pkg::OP_CMP: begin
              if (!ccle_pkg::cmp_ok(cw_q[29:27], acc_q, val_q)) begin
                if (!cw_q[31]) begin
                  skip_mode_q <= ccle_pkg::SKIP_LINES;
                  skip_left_q <= cw_q[31:30] + 2'd1;
                end else begin
                  skip_mode_q <= cw_q[31:30];
                  skip_left_q <= 2'd0;
                end
              end
              state_q <= S_OUT;
            end
            default: state_q <= S_OUT;
          endcase
        end
        S_WR: begin
          if (cnt_q == 3'd1) begin
            if (reps_q == 25'd1) begin
              state_q <= S_OUT;
            end else begin
              reps_q <= reps_q - 25'd1;
              base_q <= base_q + step_q;
              addr_q <= base_q + step_q;
              val_q  <= nval;
              wsh_q  <= ccle_pkg::align_val(nval, size_q);
              cnt_q  <= 3'd1 << size_q;
            end
          end else begin
            cnt_q  <= cnt_q - 3'd1;
            addr_q <= addr_q + AW'(1);
            wsh_q  <= {wsh_q[23:0], 8'd0};
          end
        end
        S_OUT: begin
          if (m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
